/* sv/assert_macros.svh */
// Assertion macros used by the checker file bcsd_checker.
// Each macro names one concurrent property clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/bcsd_pkg.sv */
// Package for the canvas shape drawer.
// Holds command codes, default canvas sizes and output port widths; no dependencies.
package bcsd_pkg;
    localparam int CANVAS_ROWS_DEF = 25;
    localparam int CANVAS_COLS_DEF = 60;
    localparam int ROW_BITS_W = 60;
    localparam int ROW_IDX_W = 5;

    typedef enum logic [2:0] {
        MODE_RECT   = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_TRI    = 3'd2,
        MODE_CIRCLE = 3'd3,
        MODE_CLEAR  = 3'd4,
        MODE_WIPE   = 3'd5,
        MODE_READ   = 3'd6
    } mode_t;
endpackage

/* sv/bitmap_canvas_shape_drawer.sv */
// Canvas shape drawer: a one-bit canvas kept as one word per row in a memory.
// Each command sweeps the rows. A row's word is read in S_RD and written back in S_WR,
// and the request is taken in S_IDLE before the sweep. Drawing and clearing commands
// go through S_RD and S_WR for every row. A circle runs the circle unit once per column
// of each row in S_RING before the row is written. A read hands each row from S_RD to
// the output register in S_OUT, and waits in S_OUT while the output side stalls a full
// output register. The block takes no request until the command's last row is written or
// handed to the output register; an unused mode is taken and dropped without leaving S_IDLE.
// Depends on bcsd_pkg.
module bitmap_canvas_shape_drawer #(
    parameter int CANVAS_ROWS = bcsd_pkg::CANVAS_ROWS_DEF,
    parameter int CANVAS_COLS = bcsd_pkg::CANVAS_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      mode,
    input  logic signed [7:0]               row,
    input  logic signed [7:0]               col,
    input  logic [6:0]                      height,
    input  logic [6:0]                      width,
    input  logic signed [7:0]               end_col,
    input  logic [6:0]                      radius,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bcsd_pkg::ROW_IDX_W-1:0]  row_index,
    output logic [bcsd_pkg::ROW_BITS_W-1:0] row_bits,
    output logic                            last
);
    import bcsd_pkg::*;

    localparam int RW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int CW = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_WR   = 5'b00100,
        S_RING = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CANVAS_COLS-1:0] mem [CANVAS_ROWS];
    logic [CANVAS_ROWS-1:0] vld_reg;
    logic [CANVAS_COLS-1:0] rdata_reg, word_reg, word_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [2:0] mode_reg;
    logic signed [9:0] row_reg, col_reg, ecol_reg;
    logic [6:0] h_reg, w_reg, rad_reg;
    logic [14:0] lo_reg, hi_reg;
    logic ov_reg;
    logic [ROW_IDX_W-1:0] oi_reg;
    logic [ROW_BITS_W-1:0] ob_reg;
    logic ol_reg;
    logic rlast;
    logic [CANVAS_COLS-1:0] rowval;
    logic signed [9:0] rs, lft, rgt, dy;
    logic signed [10:0] dx;
    logic [15:0] d2;
    logic hit;
    logic wr_en;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign row_index = oi_reg;
    assign row_bits  = ob_reg;
    assign last      = ol_reg;
    assign rlast     = (r_reg == RW'(CANVAS_ROWS - 1));
    assign rowval    = vld_reg[r_reg] ? rdata_reg : '0;
    assign rs        = $signed({1'b0, r_reg}) - row_reg;

    function automatic logic [CANVAS_COLS-1:0] span(input logic signed [9:0] a,
                                                    input logic signed [9:0] b);
        logic [CANVAS_COLS-1:0] m;
        m = '0;
        for (int j = 0; j < CANVAS_COLS; j++)
            if (j >= a && j <= b)
                m[j] = 1'b1;
        return m;
    endfunction

    // shared unit: row mask for the current command
    always_comb
    begin
        word_next = rowval;
        lft = col_reg;
        rgt = col_reg + $signed({3'b0, w_reg}) - 10'sd1;
        case (mode_reg)
            MODE_RECT:
            begin
                if (h_reg != 0 && w_reg != 0 && rs >= 0 && rs < $signed({3'b0, h_reg}))
                begin
                    if (rs == 0 || rs == $signed({3'b0, h_reg}) - 10'sd1)
                        word_next = rowval | span(lft, rgt);
                    else
                        word_next = rowval | span(lft, lft) | span(rgt, rgt);
                end
            end
            MODE_LINE:
                if (rs == 0)
                    word_next = rowval | span(col_reg, ecol_reg);
            MODE_TRI:
                if (rs >= 0 && rs < $signed({3'b0, h_reg}))
                    word_next = rowval | span(col_reg, col_reg + rs);
            MODE_CLEAR:
                if (h_reg != 0 && w_reg != 0 && rs >= 0 && rs < $signed({3'b0, h_reg}))
                    word_next = rowval & ~span(lft, rgt);
            MODE_WIPE:
                word_next = '0;
            default:
                word_next = rowval;
        endcase
    end

    // circle: one column per cycle through two multipliers and an adder
    assign dx  = {rs[9], rs};
    assign dy  = $signed({1'b0, c_reg}) - col_reg;
    assign d2  = 16'(dx * dx) + 16'(dy * dy);
    assign hit = (rad_reg == 0) ? (d2 == 0)
               : (d2 >= {1'b0, lo_reg} && d2 <= {1'b0, hi_reg});

    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        c_next = c_reg;
        wr_en = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    r_next = '0;
                    c_next = '0;
                    if (mode == MODE_READ || (mode inside {[MODE_RECT:MODE_WIPE]}))
                        state_next = S_RD;
                end
            S_RD:
                if (mode_reg == MODE_READ)
                    state_next = S_OUT;
                else if (mode_reg == MODE_CIRCLE)
                    state_next = S_RING;
                else
                    state_next = S_WR;
            S_WR:
            begin
                wr_en = 1'b1;
                r_next = r_reg + 1'b1;
                state_next = rlast ? S_IDLE : S_RD;
            end
            S_RING:
                if (c_reg == CW'(CANVAS_COLS - 1))
                begin
                    wr_en = 1'b1;
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                    state_next = rlast ? S_IDLE : S_RD;
                end
                else
                    c_next = c_reg + 1'b1;
            S_OUT:
                if (!ov_reg || !out_stall)
                begin
                    r_next = r_reg + 1'b1;
                    state_next = rlast ? S_IDLE : S_RD;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg <= '0;
            c_reg <= '0;
            vld_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg <= r_next;
            c_reg <= c_next;
            if (wr_en)
                vld_reg[r_reg] <= 1'b1;
            if (state_reg == S_OUT && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg <= mode;
            row_reg  <= 10'(row);
            col_reg  <= 10'(col);
            ecol_reg <= 10'(end_col);
            h_reg    <= height;
            w_reg    <= width;
            rad_reg  <= radius;
            lo_reg   <= 15'(radius * radius) - 15'(radius) + 15'd1;
            hi_reg   <= 15'(radius * radius) + 15'(radius);
        end
        rdata_reg <= mem[r_reg];
        if (state_reg == S_RD)
            word_reg <= '0;
        else if (state_reg == S_RING && hit)
            word_reg[c_reg] <= 1'b1;
        if (wr_en)
            mem[r_reg] <= (state_reg == S_RING)
                        ? (rowval | word_reg | (hit ? (CANVAS_COLS'(1) << c_reg) : '0))
                        : word_next;
        if (state_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            oi_reg <= ROW_IDX_W'(r_reg);
            ob_reg <= ROW_BITS_W'(rowval);
            ol_reg <= rlast;
        end
    end
endmodule

/* sv/bcsd_checker.sv */
// Port checker for the canvas shape drawer.
// Depends on assert_macros.svh and bcsd_pkg; bound to bitmap_canvas_shape_drawer.
`include "assert_macros.svh"
module bcsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] mode,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] row_index,
    input logic       last
);
    import bcsd_pkg::*;

    `ASSERT_NXT(a_busy_after_req, in_valid && !in_stall && mode <= MODE_READ, in_stall)
    `ASSERT_IMP(a_no_out_idle, out_valid && !out_stall && !last, in_stall)
    `ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(row_index))
    `ASSERT_IMP(a_last_row, out_valid && last, row_index == 5'(CANVAS_ROWS_DEF - 1))
endmodule

bind bitmap_canvas_shape_drawer bcsd_checker u_bcsd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index), .last(last)
);

/* sim/bitmap_canvas_shape_drawer_tb.sv */
// Self-checking bench for the one-bit canvas shape drawer.
// Predicts each canvas readout from a local copy of the canvas and checks every row word.
// Depends on bcsd_pkg and bitmap_canvas_shape_drawer.
module bitmap_canvas_shape_drawer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bcsd_pkg::*;

    localparam int NROWS = CANVAS_ROWS_DEF;
    localparam int NCOLS = CANVAS_COLS_DEF;
    localparam int CYCLE_LIMIT = 900000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0] mode;
        logic signed [7:0] row;
        logic signed [7:0] col;
        logic [6:0] height;
        logic [6:0] width;
        logic signed [7:0] end_col;
        logic [6:0] radius;
    } command_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] idx;
        logic [ROW_BITS_W-1:0] bits;
        logic last;
    } row_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] mode = '0;
    logic signed [7:0] row = '0;
    logic signed [7:0] col = '0;
    logic [6:0] height = '0;
    logic [6:0] width = '0;
    logic signed [7:0] end_col = '0;
    logic [6:0] radius = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic last;

    command_t pending_cmds[$];
    row_word_t expected_rows[$];
    logic [NCOLS-1:0] canvas_model[NROWS];
    int errors = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 76;
    int hold_off = 0;
    logic hold_req = 1'b0;
    int unsigned cycles = 0;

    bitmap_canvas_shape_drawer dut (.*);

    always #10 clk = ~clk;

    task automatic set_cell(int r, int c, bit on);
        if (r >= 0 && r < NROWS && c >= 0 && c < NCOLS)
            canvas_model[r][c] = on;
    endtask

    task automatic apply_command(command_t cmd);
        int r, c, h, w, ec, rad, d2;
        r = cmd.row;
        c = cmd.col;
        h = cmd.height;
        w = cmd.width;
        ec = cmd.end_col;
        rad = cmd.radius;
        case (cmd.mode)
            MODE_RECT:
                if (h != 0 && w != 0)
                begin
                    for (int j = c; j < c + w; j++)
                    begin
                        set_cell(r, j, 1);
                        set_cell(r + h - 1, j, 1);
                    end
                    for (int i = r; i < r + h; i++)
                    begin
                        set_cell(i, c, 1);
                        set_cell(i, c + w - 1, 1);
                    end
                end
            MODE_LINE:
                for (int j = c; j <= ec; j++)
                    set_cell(r, j, 1);
            MODE_TRI:
                for (int i = 0; i < h; i++)
                    for (int j = 0; j <= i; j++)
                        set_cell(r + i, c + j, 1);
            MODE_CIRCLE:
                for (int x = 0; x < NROWS; x++)
                    for (int y = 0; y < NCOLS; y++)
                    begin
                        d2 = (x - r) * (x - r) + (y - c) * (y - c);
                        if (rad == 0 ? d2 == 0
                                     : (d2 >= rad * rad - rad + 1 && d2 <= rad * rad + rad))
                            set_cell(x, y, 1);
                    end
            MODE_CLEAR:
                for (int i = r; i < r + h; i++)
                    for (int j = c; j < c + w; j++)
                        set_cell(i, j, 0);
            MODE_WIPE:
                foreach (canvas_model[i])
                    canvas_model[i] = '0;
            MODE_READ:
                for (int i = 0; i < NROWS; i++)
                    expected_rows.push_back('{ROW_IDX_W'(i), canvas_model[i], i == NROWS - 1});
            default: ;
        endcase
    endtask

    function automatic command_t make_cmd(logic [2:0] m, int r, int c, int h, int w, int ec,
                                          int rad);
        command_t cmd;
        cmd.mode = m;
        cmd.row = r[7:0];
        cmd.col = c[7:0];
        cmd.height = h[6:0];
        cmd.width = w[6:0];
        cmd.end_col = ec[7:0];
        cmd.radius = rad[6:0];
        return cmd;
    endfunction

    function automatic int near_coord(int span);
        if ($urandom_range(0, 9) == 0)
            return $signed(8'($urandom));
        return $urandom_range(0, span + 6) - 4;
    endfunction

    function automatic command_t random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0);
        if (r < 10)
            return make_cmd(MODE_WIPE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (r < 12)
            return make_cmd(3'd7, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (r < 14)
            return command_t'(48'({$urandom, $urandom}));
        return make_cmd($urandom_range(0, 4), near_coord(NROWS), near_coord(NCOLS),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 30),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 65),
                        near_coord(NCOLS),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 30));
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                command_t cmd;
                cmd = pending_cmds.pop_front();
                apply_command(cmd);
                in_valid <= 1'b1;
                {mode, row, col, height, width, end_col, radius} <= cmd;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_req)
            hold_off <= HOLD_CYCLES;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                row_word_t want;
                if (expected_rows.size() == 0)
                begin
                    $display("%0t: unexpected row idx=%0d bits=%h last=%b", $realtime, row_index,
                             row_bits, last);
                    errors++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (row_index !== want.idx)
                    begin
                        $display("%0t: row_index expected %0d actual %0d", $realtime, want.idx,
                                 row_index);
                        errors++;
                    end
                    if (row_bits !== want.bits)
                    begin
                        $display("%0t: row_bits row %0d expected %h actual %h", $realtime,
                                 want.idx, want.bits, row_bits);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last row %0d expected %b actual %b", $realtime, want.idx,
                                 want.last, last);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
                out_stall <= 1'b1;
            else
                out_stall <= $urandom_range(0, 99) < recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_rows.size() > 0)
            @(posedge clk);
        repeat (NROWS * (NCOLS + 1) + 50) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_RECT, 0, 0, NROWS, NCOLS, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_RECT, -128, -128, 127, 127, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_RECT, 3, 3, 0, 5, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_RECT, 3, 3, 5, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_LINE, 5, -128, 0, 0, 127, 0));
        pending_cmds.push_back(make_cmd(MODE_LINE, 7, 20, 0, 0, 10, 0));
        pending_cmds.push_back(make_cmd(MODE_LINE, -1, 0, 0, 0, 59, 0));
        pending_cmds.push_back(make_cmd(MODE_TRI, 10, -3, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_TRI, 10, 10, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_WIPE, 127, 127, 127, 127, 127, 127));
        pending_cmds.push_back(make_cmd(MODE_CIRCLE, 12, 30, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CIRCLE, 12, 30, 0, 0, 0, 10));
        pending_cmds.push_back(make_cmd(MODE_CIRCLE, -128, 127, 0, 0, 0, 127));
        pending_cmds.push_back(make_cmd(MODE_CIRCLE, 0, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CLEAR, -5, -5, 127, 127, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_RECT, 2, 2, 10, 20, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CLEAR, 4, 4, 3, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_CLEAR, 1, 1, 5, 8, 0, 0));
        pending_cmds.push_back(make_cmd(3'd7, -1, -1, 127, 127, -1, 127));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        drain();
        for (int i = 0; i < 80; i++)
            pending_cmds.push_back(random_cmd());
        drain();
        send_idle_pct = 76;
        recv_idle_pct = 31;
        for (int i = 0; i < 80; i++)
            pending_cmds.push_back(random_cmd());
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 80; i++)
            pending_cmds.push_back(random_cmd());
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/bcsd_pkg.sv
sv/bitmap_canvas_shape_drawer.sv
sv/bcsd_checker.sv
sim/bitmap_canvas_shape_drawer_tb.sv
